// ----- hdl/vmbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbs_pkg: shared types and constants
// Widths, plane store geometry and the control structs exchanged between the
// position generator, the accumulator and the top level.
// ----------------------------------------------------------------------------
package vmbs_pkg;

    localparam int MAX_EDGE = 256;
    localparam int MAX_LG   = $clog2(MAX_EDGE);
    localparam int POS_W    = MAX_LG;
    localparam int HALF_W   = MAX_LG - 1;
    localparam int ADDR_W   = 2 * HALF_W;
    localparam int PLANE_DEPTH = (MAX_EDGE / 2) * (MAX_EDGE / 2);

    localparam int LG_W   = 4;
    localparam int CHAN_W = 32;
    localparam int PAIR_W = 33;
    localparam int SUM_W  = 35;
    localparam int RAM_W  = 3 * SUM_W;

    localparam logic [LG_W-1:0] LG_RESET = LG_W'(8);
    localparam logic [LG_W-1:0] LG_MIN   = LG_W'(1);
    localparam logic [LG_W-1:0] LG_MAX   = LG_W'(MAX_LG);

    // Per-voxel control derived from the current position
    typedef struct packed {
        logic              odd_x;     // second voxel of an x pair
        logic              first;     // group slot opens (y even, z even)
        logic              emit;      // group closes (y odd, z odd)
        logic              last;      // final voxel of the level
        logic [ADDR_W-1:0] addr;      // plane store entry
    } vox_info_t;

    // Accumulator status toward the input handshake
    typedef struct packed {
        logic busy;   // stage 1 holds an item
        logic adv;    // stage 1 item leaves this cycle
    } acc_stat_t;

endpackage

// ----- hdl/vmbs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vmbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/vmbs_pos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbs_pos: raster position generator
// Holds the edge size and the x/y/z position of the next voxel, and derives
// the group flags and plane store address for it.
// ----------------------------------------------------------------------------
module vmbs_pos (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_fire,
    input  logic [vmbs_pkg::LG_W-1:0]     cfg_lg,
    input  logic                          in_fire,
    output vmbs_pkg::vox_info_t           info
);

    logic [vmbs_pkg::POS_W-1:0] pos_x_reg, pos_x_next;
    logic [vmbs_pkg::POS_W-1:0] pos_y_reg, pos_y_next;
    logic [vmbs_pkg::POS_W-1:0] pos_z_reg, pos_z_next;
    logic [vmbs_pkg::LG_W-1:0]  lg_m1_reg, lg_m1_next;
    logic [vmbs_pkg::POS_W-1:0] mask_reg, mask_next;
    logic [vmbs_pkg::LG_W-1:0]  lg_eff;
    logic [vmbs_pkg::ADDR_W-1:0] row_base;

    // clamp the register value to the legal range
    always_comb begin
        priority if (cfg_lg < vmbs_pkg::LG_MIN) begin
            lg_eff = vmbs_pkg::LG_MIN;
        end else if (cfg_lg > vmbs_pkg::LG_MAX) begin
            lg_eff = vmbs_pkg::LG_MAX;
        end else begin
            lg_eff = cfg_lg;
        end
    end

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        lg_m1_next = lg_m1_reg;
        mask_next  = mask_reg;
        if (cfg_fire) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
            lg_m1_next = lg_eff - vmbs_pkg::LG_W'(1);
            mask_next  = vmbs_pkg::POS_W'((
                (vmbs_pkg::POS_W+1)'(1) << lg_eff) - (vmbs_pkg::POS_W+1)'(1));
        end else if (in_fire) begin
            pos_x_next = pos_x_reg + vmbs_pkg::POS_W'(1);
            if (pos_x_reg == mask_reg) begin
                pos_x_next = '0;
                pos_y_next = pos_y_reg + vmbs_pkg::POS_W'(1);
                if (pos_y_reg == mask_reg) begin
                    pos_y_next = '0;
                    pos_z_next = (pos_z_reg == mask_reg) ? '0
                                 : pos_z_reg + vmbs_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            lg_m1_reg <= vmbs_pkg::LG_RESET - vmbs_pkg::LG_W'(1);
            mask_reg  <= '1;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            lg_m1_reg <= lg_m1_next;
            mask_reg  <= mask_next;
        end
    end

    // entry = (y/2) * (edge/2) + x/2
    assign row_base = vmbs_pkg::ADDR_W'(pos_y_reg[vmbs_pkg::POS_W-1:1]) << lg_m1_reg;

    always_comb begin
        info.odd_x = pos_x_reg[0];
        info.first = !pos_y_reg[0] && !pos_z_reg[0];
        info.emit  = pos_y_reg[0] && pos_z_reg[0];
        info.last  = (pos_x_reg == mask_reg) && (pos_y_reg == mask_reg) &&
                     (pos_z_reg == mask_reg);
        info.addr  = row_base | vmbs_pkg::ADDR_W'(pos_x_reg[vmbs_pkg::POS_W-1:1]);
    end

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_fire |=> (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0))
        else $error("position not restarted after register write");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((pos_x_reg & ~mask_reg) == '0) && ((pos_y_reg & ~mask_reg) == '0) &&
        ((pos_z_reg & ~mask_reg) == '0))
        else $error("position beyond edge");

endmodule

// ----- hdl/vmbs_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmbs_accum: pair register, read-add-write stage and output register
// Even-x voxels park in the pair register. Odd-x voxels add the pair, read
// the plane entry unless the group slot opens, and in stage 1 either write
// the partial sum back or hand the finished group to the output register.
// ----------------------------------------------------------------------------
module vmbs_accum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_fire,
    input  vmbs_pkg::vox_info_t                 info,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_a,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_b,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_c,
    output logic                                ram_re,
    output logic [vmbs_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [vmbs_pkg::RAM_W-1:0]          ram_rdata,
    output logic                                ram_we,
    output logic [vmbs_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [vmbs_pkg::RAM_W-1:0]          ram_wdata,
    output vmbs_pkg::acc_stat_t                 stat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_a,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_b,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_c,
    output logic                                m_last_of_level
);

    localparam int SW = vmbs_pkg::SUM_W;
    localparam int PW = vmbs_pkg::PAIR_W;

    logic signed [vmbs_pkg::CHAN_W-1:0] pair_a_reg, pair_b_reg, pair_c_reg;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_first_reg, s1_emit_reg, s1_last_reg;
    logic [vmbs_pkg::ADDR_W-1:0] s1_addr_reg;
    logic signed [PW-1:0]        s1_pa_reg, s1_pb_reg, s1_pc_reg;

    logic signed [SW-1:0] plane_a, plane_b, plane_c;
    logic signed [SW-1:0] sum_a, sum_b, sum_c;

    logic m_valid_reg, m_valid_next;
    logic signed [SW-1:0] m_sum_a_reg, m_sum_b_reg, m_sum_c_reg;
    logic m_last_reg;

    logic s1_adv, out_load;

    // stage 0: pair register and read issue
    always_ff @(posedge aclk) begin
        if (in_fire && !info.odd_x) begin
            pair_a_reg <= s_chan_a;
            pair_b_reg <= s_chan_b;
            pair_c_reg <= s_chan_c;
        end
    end

    assign ram_re    = in_fire && info.odd_x && !info.first;
    assign ram_raddr = info.addr;

    // stage 1 advances unless it holds a finished group the output can't take
    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign out_load = s1_adv && s1_emit_reg;
    assign stat.busy = s1_valid_reg;
    assign stat.adv  = s1_adv;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && info.odd_x) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && info.odd_x) begin
            s1_first_reg <= info.first;
            s1_emit_reg  <= info.emit;
            s1_last_reg  <= info.last;
            s1_addr_reg  <= info.addr;
            s1_pa_reg    <= PW'(pair_a_reg) + PW'(s_chan_a);
            s1_pb_reg    <= PW'(pair_b_reg) + PW'(s_chan_b);
            s1_pc_reg    <= PW'(pair_c_reg) + PW'(s_chan_c);
        end
    end

    // stage 1: add the plane entry (none when the group slot opens)
    always_comb begin
        plane_a = s1_first_reg ? '0 : ram_rdata[SW-1:0];
        plane_b = s1_first_reg ? '0 : ram_rdata[2*SW-1:SW];
        plane_c = s1_first_reg ? '0 : ram_rdata[3*SW-1:2*SW];
        sum_a   = SW'(s1_pa_reg) + plane_a;
        sum_b   = SW'(s1_pb_reg) + plane_b;
        sum_c   = SW'(s1_pc_reg) + plane_c;
    end

    assign ram_we    = s1_valid_reg && !s1_emit_reg;
    assign ram_waddr = s1_addr_reg;
    assign ram_wdata = {sum_c, sum_b, sum_a};

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sum_a_reg <= sum_a;
            m_sum_b_reg <= sum_b;
            m_sum_c_reg <= sum_c;
            m_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sum_a         = m_sum_a_reg;
    assign m_sum_b         = m_sum_b_reg;
    assign m_sum_c         = m_sum_c_reg;
    assign m_last_of_level = m_last_reg;

    a_no_write_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s1_emit_reg && s1_valid_reg)
        else $error("plane write from a closing group");

    a_stall_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |-> s1_emit_reg && m_valid_reg && !m_ready)
        else $error("stage 1 stalled without a blocked output");

endmodule

// ----- hdl/volume_mip_box_sum_2x2x2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_mip_box_sum_2x2x2: 2x2x2 box-sum mip reducer
// Sums every aligned 2x2x2 group of a raster-order three-channel cube into
// one voxel of the half-size level, using a plane store of partial sums.
// ----------------------------------------------------------------------------
// Throughput: one voxel item per cycle while the m_ output is not stalled; set by the
//   single read-add-write of the plane store per odd-x voxel.
// Path: the last voxel of a group is registered into stage 1 with its plane
//   read, then its sum is added into the output register that drives m_.
// Reset: synchronous active-low aresetn clears position, pipeline valids and
//   sets edge_log2 to 8. The plane store is not cleared: every entry is
//   written in a level before it is read.
// ----------------------------------------------------------------------------
module volume_mip_box_sum_2x2x2 (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: edge_log2
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vmbs_pkg::LG_W-1:0]           cfg_edge_log2,
    // voxel items in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_a,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_b,
    input  logic signed [vmbs_pkg::CHAN_W-1:0]  s_chan_c,
    // group sums out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_a,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_b,
    output logic signed [vmbs_pkg::SUM_W-1:0]   m_sum_c,
    output logic                                m_last_of_level
);

    vmbs_pkg::vox_info_t  info;
    vmbs_pkg::acc_stat_t  stat;

    logic cfg_fire, in_fire;

    logic                          ram_re, ram_we;
    logic [vmbs_pkg::ADDR_W-1:0]   ram_raddr, ram_waddr;
    logic [vmbs_pkg::RAM_W-1:0]    ram_rdata, ram_wdata;

    // Register writes are always taken. The user must let them land only while idle; the block does not enforce this.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Take an item whenever stage 1 is free or emptying this cycle. The
    // output register plus stage 1 give a two-deep cushion toward m_.
    assign s_ready = !stat.busy || stat.adv;
    assign in_fire = s_valid && s_ready;

    vmbs_pos u_pos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_fire (cfg_fire),
        .cfg_lg   (cfg_edge_log2),
        .in_fire  (in_fire),
        .info     (info)
    );

    // Plane store: {c, b, a} partial sums, one entry per group column.
    vmbs_ram #(
        .WIDTH (vmbs_pkg::RAM_W),
        .DEPTH (vmbs_pkg::PLANE_DEPTH)
    ) u_plane (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vmbs_accum u_accum (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_fire         (in_fire),
        .info            (info),
        .s_chan_a        (s_chan_a),
        .s_chan_b        (s_chan_b),
        .s_chan_c        (s_chan_c),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_a         (m_sum_a),
        .m_sum_b         (m_sum_b),
        .m_sum_c         (m_sum_c),
        .m_last_of_level (m_last_of_level)
    );

    // Consecutive plane accesses never hit the same entry, so the store
    // needs no forwarding path.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("plane read and write collide on one entry");

    a_ready_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output is free");

    a_even_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !info.odd_x) |=> !ram_we)
        else $error("plane write after an even-x item");

endmodule
